/* hdl/ssrc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sorted store rank count unit.
// Used by the entry stage, the cells and the top level; no dependencies.
package ssrc_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int VALUE_BITS_DEF = 10;
	localparam int COUNT_BITS     = 11;
	localparam int OP_BITS        = 2;
	localparam int OUT_DATA_BITS  = 16;

	localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_BITS-1:0] OP_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		TK_NOP,
		TK_CLEAR,
		TK_INSERT,
		TK_QUERY
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t kind;
		logic      ovf;
	} tok_ctl_t;

endpackage

/* hdl/sorted_store_rank_count_unit.sv */
`timescale 1ns / 1ps
// Top level of the sorted store rank count unit: entry stage, chain of
// CAPACITY cells and output register; uses ssrc_pkg, ssrc_entry, ssrc_cell.
//
// The store is a systolic chain of CAPACITY cells, each holding one value,
// kept in ascending order with equal values in arrival order. Every beat
// enters the chain as a token that moves one cell per cycle: an insert
// ripples larger values to the right, a clear empties each cell it passes,
// and a query counts the held values that are less than or equal to it. A
// new beat is taken every cycle while the output side keeps up; a query
// result passes through the token register of every cell in the chain and
// then the output register. An insert into a full store is dropped at the
// entry and sets the sticky overflow flag that every later query reports
// until a clear. A stall on the output side holds the whole chain.
module sorted_store_rank_count_unit import ssrc_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// Fields from bit 0: value, zero padding.
	input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
	// Fields from bit 0: op.
	input  logic [OP_BITS-1:0]                    s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// Fields from bit 0: count (11 bits), overflow, zero padding.
	output logic [OUT_DATA_BITS-1:0]              m_axis_tdata
);

	localparam int CNT_BITS = $clog2(CAPACITY + 1);

	logic                  advance;
	logic                  accept;
	tok_ctl_t              ctl_c   [0:CAPACITY];
	logic [VALUE_BITS-1:0] value_c [0:CAPACITY];
	logic [CNT_BITS-1:0]   count_c [0:CAPACITY];

	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] out_count_q;
	logic                  out_ovf_q;
	logic [CNT_BITS+COUNT_BITS-1:0] count_ext;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = advance;
	assign accept        = s_axis_tvalid && advance;

	ssrc_entry #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS),
		.CNT_BITS   (CNT_BITS)
	) u_entry (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (s_axis_tuser),
		.value     (s_axis_tdata[VALUE_BITS-1:0]),
		.tok_ctl   (ctl_c[0]),
		.tok_value (value_c[0]),
		.tok_count (count_c[0])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ssrc_cell #(
			.VALUE_BITS (VALUE_BITS),
			.CNT_BITS   (CNT_BITS)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.in_ctl    (ctl_c[i]),
			.in_value  (value_c[i]),
			.in_count  (count_c[i]),
			.out_ctl   (ctl_c[i+1]),
			.out_value (value_c[i+1]),
			.out_count (count_c[i+1])
		);
	end

	assign count_ext = {{COUNT_BITS{1'b0}}, count_c[CAPACITY]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= (ctl_c[CAPACITY].kind == TK_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (ctl_c[CAPACITY].kind == TK_QUERY)) begin
			out_count_q <= count_ext[COUNT_BITS-1:0];
			out_ovf_q   <= ctl_c[CAPACITY].ovf;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_BITS - COUNT_BITS - 1){1'b0}}, out_ovf_q, out_count_q};

endmodule

/* hdl/ssrc_entry.sv */
`timescale 1ns / 1ps
// Entry stage: turns accepted input beats into tokens for the cell chain.
// Keeps the occupancy count and sticky overflow flag; uses ssrc_pkg.
module ssrc_entry import ssrc_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int CNT_BITS   = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [OP_BITS-1:0]    op,
	input  logic [VALUE_BITS-1:0] value,
	output tok_ctl_t              tok_ctl,
	output logic [VALUE_BITS-1:0] tok_value,
	output logic [CNT_BITS-1:0]   tok_count
);

	logic [CNT_BITS-1:0] occ_q;
	logic                ovf_q;
	logic                full;

	assign full = (occ_q == CNT_BITS'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			unique case (op)
				OP_CLEAR: begin
					occ_q <= '0;
					ovf_q <= 1'b0;
				end
				OP_INSERT: begin
					if (full) begin
						ovf_q <= 1'b1;
					end else begin
						occ_q <= occ_q + CNT_BITS'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		tok_ctl.kind = TK_NOP;
		tok_ctl.ovf  = ovf_q;
		if (accept) begin
			unique case (op)
				OP_CLEAR:  tok_ctl.kind = TK_CLEAR;
				OP_INSERT: tok_ctl.kind = full ? TK_NOP : TK_INSERT;
				OP_QUERY:  tok_ctl.kind = TK_QUERY;
				default:   tok_ctl.kind = TK_NOP;
			endcase
		end
	end

	assign tok_value = value;
	assign tok_count = '0;

endmodule

/* hdl/ssrc_cell.sv */
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one stored value and its occupied bit,
// and passes a registered token to its right neighbor; uses ssrc_pkg.
module ssrc_cell import ssrc_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int CNT_BITS   = $clog2(CAPACITY_DEF + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  tok_ctl_t              in_ctl,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic [CNT_BITS-1:0]   in_count,
	output tok_ctl_t              out_ctl,
	output logic [VALUE_BITS-1:0] out_value,
	output logic [CNT_BITS-1:0]   out_count
);

	logic                  occ_q;
	logic [VALUE_BITS-1:0] data_q;
	tok_ctl_t              tok_ctl_q;
	logic [VALUE_BITS-1:0] tok_value_q;
	logic [CNT_BITS-1:0]   tok_count_q;

	logic                  occ_d;
	logic [VALUE_BITS-1:0] data_d;
	tok_ctl_t              ctl_d;
	logic [VALUE_BITS-1:0] value_d;
	logic [CNT_BITS-1:0]   count_d;
	logic                  hit;

	assign hit = occ_q && (data_q <= in_value);

	always_comb begin
		occ_d   = occ_q;
		data_d  = data_q;
		ctl_d   = in_ctl;
		value_d = in_value;
		count_d = in_count;
		unique case (in_ctl.kind)
			TK_CLEAR: begin
				occ_d = 1'b0;
			end
			TK_INSERT: begin
				if (!occ_q) begin
					occ_d      = 1'b1;
					data_d     = in_value;
					ctl_d.kind = TK_NOP;
				end else if (data_q > in_value) begin
					data_d  = in_value;
					value_d = data_q;
				end
			end
			TK_QUERY: begin
				count_d = in_count + CNT_BITS'(hit);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q          <= 1'b0;
			tok_ctl_q.kind <= TK_NOP;
			tok_ctl_q.ovf  <= 1'b0;
		end else if (advance) begin
			occ_q     <= occ_d;
			tok_ctl_q <= ctl_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q      <= data_d;
			tok_value_q <= value_d;
			tok_count_q <= count_d;
		end
	end

	assign out_ctl   = tok_ctl_q;
	assign out_value = tok_value_q;
	assign out_count = tok_count_q;

endmodule
